>>> hdl/mbims_pkg.sv
package mbims_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // mask modes
  localparam logic [1:0] MODE_CUT_ABOVE = 2'd0;
  localparam logic [1:0] MODE_CUT_BELOW = 2'd1;
  localparam logic [1:0] MODE_MULTIPLY  = 2'd2;
  localparam logic [1:0] MODE_PASS      = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_MASK_MODE     = 2'd0;
  localparam logic [1:0] REG_SUBTRACT_MEAN = 2'd1;
  localparam logic [1:0] REG_CUT_ENABLE    = 2'd2;
  localparam logic [1:0] REG_CUT_VALUE     = 2'd3;

  // opcode in tuser
  localparam logic OP_PASS1 = 1'b0;
  localparam logic OP_PASS2 = 1'b1;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // magnitude of the most negative Q16.16 value
  localparam logic [DATA_W:0] Q_NEG_LIMIT = 33'h0_8000_0000;

  typedef struct packed {
    logic take_en;    // input may be taken
    logic clr;        // word starts a new volume (pass 1 after closed pass)
    logic use_mean;   // region mean is ready
    logic div_start;  // launch mean division
  } mbims_cmd_t;

  typedef struct packed {
    logic accept;       // input word taken this cycle
    logic s1_empty;     // no word in the first stage
    logic mean_wanted;  // subtract_mean set and weight positive
    logic div_done;     // mean division finished
  } mbims_stat_t;

endpackage

>>> hdl/mask_by_image_mean_subtract_top.sv
// Voxel masker with region-mean subtraction, signed Q16.16 throughout.
// Pass-1 words (tuser = 0) are masked against their mask voxel by mask_mode
// and, with cut_enable set, summed into saturating ACC_WIDTH-bit masked-sum
// and weight accumulators. The pass-1 word with tlast closes the pass; if
// subtract_mean is set and the weight is positive, the region mean
// sum * 2^16 / weight is formed. Pass-2 words (tuser = 1) then come out with
// that mean subtracted (out_tuser = 1) unless mask_mode is pass; without a
// mean, or in pass mode, they get the pass-1 treatment. The first pass-1
// word after a closed pass clears all sums. Throughput is one word per clock
// while out_tready is high and no pass is being closed. A taken word sits in
// the multiply stage register and moves on through the saturate/accumulate
// stage into the output register once that is free or out_tready is high.
// After the last pass-1 word the input stalls while that word retires (longer
// while out_tready holds it back) and, when a mean is formed, while the
// one-bit-per-cycle restoring divider works out its ACC_WIDTH + 16 quotient
// bits and hands the mean back. Config writes are always taken (cfg_ready
// stays high) and must only be issued while the block is idle.
module mask_by_image_mean_subtract_top
  import mbims_pkg::*;
#(
  parameter int ACC_WIDTH = 64   // accumulator width, 40..64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input voxel channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,   // [31:0] pixel_value, [63:32] mask_value
  input  logic               in_tuser,   // [0] opcode
  input  logic               in_tlast,   // last
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // [31:0] pixel_out
  output logic               out_tuser,  // [0] mean_valid
  output logic               out_tlast,  // last_out
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  mbims_cmd_t  cmd;
  mbims_stat_t stat;

  assign cfg_ready = 1'b1;

  // controller: pass state, drain and divide sequencing
  mbims_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_opcode (in_tuser),
    .in_last   (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: pipe, accumulators, divider, output register
  mbims_dp #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

>>> hdl/mbims_div.sv
// Restoring divider: mean = sat32(trunc(s * 2^16 / w)), w > 0.
// One quotient bit per cycle, ACC_WIDTH + 16 quotient bits in all.
module mbims_div
  import mbims_pkg::*;
#(
  parameter int ACC_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [ACC_WIDTH-1:0] sum_in,
  input  logic signed [ACC_WIDTH-1:0] wt_in,
  output logic                        done,
  output logic signed [DATA_W-1:0]    mean
);

  localparam int NUM_W = ACC_WIDTH + FRAC_W;
  localparam int CNT_W = $clog2(NUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [ACC_WIDTH-1:0] rem_r, rem_nxt;
  logic [ACC_WIDTH-1:0] wt_r, wt_nxt;
  logic [DATA_W:0]      quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 neg_r, neg_nxt;

  logic [ACC_WIDTH-1:0] mag;
  logic [ACC_WIDTH:0]   r2;
  logic [ACC_WIDTH:0]   r2_sub;
  logic                 ge;

  assign mag    = sum_in[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - sum_in) : sum_in;
  assign r2     = {rem_r, num_r[NUM_W-1]};
  assign r2_sub = r2 - {1'b0, wt_r};
  assign ge     = (r2 >= {1'b0, wt_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    wt_nxt   = wt_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {mag, {FRAC_W{1'b0}}};
      rem_nxt  = '0;
      wt_nxt   = wt_in;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
      neg_nxt  = sum_in[ACC_WIDTH-1];
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      rem_nxt = ge ? r2_sub[ACC_WIDTH-1:0] : r2[ACC_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_W-1:0], ge};
      ovf_nxt = ovf_r | quo_r[DATA_W];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    wt_r  <= wt_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      if (ovf_r || (quo_r > Q_NEG_LIMIT)) mean = Q_MIN;
      else                                mean = DATA_W'(({DATA_W+1{1'b0}}) - quo_r);
    end else begin
      if (ovf_r || (quo_r[DATA_W:DATA_W-1] != 2'b00)) mean = Q_MAX;
      else                                           mean = quo_r[DATA_W-1:0];
    end
  end

  assign done = done_r;

endmodule

>>> hdl/mbims_dp.sv
// Datapath: config registers, two-stage voxel pipe, accumulators, mean divider.
module mbims_dp
  import mbims_pkg::*;
#(
  parameter int ACC_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbims_cmd_t           cmd,
  output mbims_stat_t          stat,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*DATA_W-1:0]  in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int PROD_W = 2*DATA_W + 1;
  localparam int FL_W   = PROD_W - FRAC_W;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  function automatic logic signed [ACC_WIDTH-1:0] acc_add(
    input logic signed [ACC_WIDTH-1:0] s,
    input logic signed [DATA_W-1:0]    d
  );
    logic signed [ACC_WIDTH:0] t;
    t = {s[ACC_WIDTH-1], s} + {{(ACC_WIDTH+1-DATA_W){d[DATA_W-1]}}, d};
    if (t[ACC_WIDTH] != t[ACC_WIDTH-1]) return t[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    return t[ACC_WIDTH-1:0];
  endfunction

  // config
  logic [1:0]               mode_r;
  logic                     sub_mean_r;
  logic                     cut_en_r;
  logic signed [DATA_W-1:0] cut_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CUT_ABOVE;
      sub_mean_r <= 1'b0;
      cut_en_r   <= 1'b0;
      cut_val_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MASK_MODE:     mode_r     <= cfg_data[1:0];
        REG_SUBTRACT_MEAN: sub_mean_r <= cfg_data[0];
        REG_CUT_ENABLE:    cut_en_r   <= cfg_data[0];
        REG_CUT_VALUE:     cut_val_r  <= cfg_data;
        default:           mode_r     <= mode_r;
      endcase
    end
  end

  // stage 1: operand select and multiply
  logic signed [DATA_W-1:0] pix, mask;
  logic signed [DATA_W:0]   pix_x, diff, opnd;
  logic                     applied, cut, accept;
  logic                     s1_v_r, out_v_r, out_load;

  logic signed [DATA_W-1:0] mean_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic signed [DATA_W:0]   s1_diff_r;
  logic signed [DATA_W-1:0] s1_pix_r, s1_mask_r;
  logic                     s1_second_r, s1_last_r, s1_applied_r, s1_clr_r;
  logic                     s1_cut_r, s1_wlow_r;

  assign pix     = in_tdata[DATA_W-1:0];
  assign mask    = in_tdata[2*DATA_W-1:DATA_W];
  assign pix_x   = {pix[DATA_W-1], pix};
  assign diff    = pix_x - {mean_r[DATA_W-1], mean_r};
  assign applied = (in_tuser == OP_PASS2) && cmd.use_mean && (mode_r != MODE_PASS);
  assign opnd    = applied ? diff : pix_x;
  assign cut     = ((mode_r == MODE_CUT_ABOVE) && (mask > cut_val_r)) ||
                   ((mode_r == MODE_CUT_BELOW) && (mask < cut_val_r));

  assign out_load  = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = cmd.take_en && (!s1_v_r || out_load);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (accept) s1_v_r <= 1'b1;
    else if (out_load) s1_v_r <= 1'b0;
    if (accept) begin
      s1_prod_r    <= opnd * mask;
      s1_diff_r    <= diff;
      s1_pix_r     <= pix;
      s1_mask_r    <= mask;
      s1_second_r  <= (in_tuser == OP_PASS2);
      s1_last_r    <= in_tlast;
      s1_applied_r <= applied;
      s1_clr_r     <= cmd.clr && (in_tuser == OP_PASS1);
      s1_cut_r     <= cut;
      s1_wlow_r    <= cut_en_r && (mask < cut_val_r);
    end
  end

  // stage 2: floor, saturate, select, accumulate
  logic signed [FL_W-1:0]   fl;
  logic signed [DATA_W-1:0] prod_sat, diff_sat, data, wt;
  logic signed [ACC_WIDTH-1:0] msum_r, wsum_r, msum_base, wsum_base;

  assign fl = FL_W'(s1_prod_r >>> FRAC_W);
  assign prod_sat = ((&fl[FL_W-1:DATA_W-1]) || !(|fl[FL_W-1:DATA_W-1])) ?
                    fl[DATA_W-1:0] : (fl[FL_W-1] ? Q_MIN : Q_MAX);
  assign diff_sat = (s1_diff_r[DATA_W] == s1_diff_r[DATA_W-1]) ?
                    s1_diff_r[DATA_W-1:0] : (s1_diff_r[DATA_W] ? Q_MIN : Q_MAX);

  always_comb begin
    data = s1_pix_r;
    wt   = Q_ONE;
    if (s1_applied_r) begin
      if (mode_r == MODE_MULTIPLY) data = prod_sat;
      else                         data = s1_cut_r ? '0 : diff_sat;
    end else begin
      case (mode_r) inside
        MODE_MULTIPLY: begin
          data = prod_sat;
          wt   = s1_wlow_r ? '0 : s1_mask_r;
        end
        MODE_CUT_ABOVE, MODE_CUT_BELOW: begin
          if (s1_cut_r) begin
            data = '0;
            wt   = '0;
          end
        end
        default: begin
          data = s1_pix_r;
          wt   = Q_ONE;
        end
      endcase
    end
  end

  assign msum_base = s1_clr_r ? '0 : msum_r;
  assign wsum_base = s1_clr_r ? '0 : wsum_r;

  logic                     div_done;
  logic signed [DATA_W-1:0] div_mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msum_r  <= '0;
      wsum_r  <= '0;
      mean_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_r <= 1'b1;
        if (!s1_second_r && cut_en_r) begin
          msum_r <= acc_add(msum_base, data);
          wsum_r <= acc_add(wsum_base, wt);
        end else begin
          msum_r <= msum_base;
          wsum_r <= wsum_base;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (accept && cmd.clr && (in_tuser == OP_PASS1)) mean_r <= '0;
      else if (div_done) mean_r <= div_mean;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= data;
      out_tuser <= s1_applied_r;
      out_tlast <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;

  mbims_div #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .sum_in (msum_r),
    .wt_in  (wsum_r),
    .done   (div_done),
    .mean   (div_mean)
  );

  assign stat.accept      = accept;
  assign stat.s1_empty    = !s1_v_r;
  assign stat.mean_wanted = sub_mean_r && !wsum_r[ACC_WIDTH-1] && (|wsum_r);
  assign stat.div_done    = div_done;

endmodule

>>> hdl/mbims_ctrl.sv
// Controller: pass tracking, drain after the last pass-1 word, mean division.
module mbims_ctrl
  import mbims_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_opcode,
  input  logic        in_last,
  input  mbims_stat_t stat,
  output mbims_cmd_t  cmd
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       pass_closed_r, pass_closed_nxt;
  logic       mean_ready_r, mean_ready_nxt;

  always_comb begin
    state_nxt       = state_r;
    pass_closed_nxt = pass_closed_r;
    mean_ready_nxt  = mean_ready_r;
    unique case (state_r)
      ST_RUN: begin
        if (stat.accept && (in_opcode == OP_PASS1)) begin
          if (pass_closed_r) mean_ready_nxt = 1'b0;
          pass_closed_nxt = in_last;
          if (in_last) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.s1_empty) state_nxt = stat.mean_wanted ? ST_DIV : ST_RUN;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          mean_ready_nxt = 1'b1;
          state_nxt      = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      pass_closed_r <= 1'b1;
      mean_ready_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pass_closed_r <= pass_closed_nxt;
      mean_ready_r  <= mean_ready_nxt;
    end
  end

  assign cmd.take_en   = (state_r == ST_RUN);
  assign cmd.clr       = pass_closed_r;
  assign cmd.use_mean  = mean_ready_r;
  assign cmd.div_start = (state_r == ST_DRAIN) && stat.s1_empty && stat.mean_wanted;

endmodule

>>> hdl/mbims_chk.sv
module mbims_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // closing a pass-1 run stalls the input in the following cycle
  a_pass_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && in_tlast |=> !in_tready)
    else $error("input taken right after last pass-1 word");

  // no result word leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // config writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind mask_by_image_mean_subtract_top mbims_chk u_mbims_chk (.*);

>>> tb/sv/voxel_mask_checker.sv
`timescale 1ns / 100ps

// Watches the config, voxel and result channels, keeps its own copy of the
// masking/mean state and compares every result word against it.
module voxel_mask_checker
  import mbims_pkg::*;
#(
  parameter int ACC_W = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] pixel;
    logic        mean_used;
    logic        last_out;
  } voxel_res_t;

  voxel_res_t expected_voxels[$];

  // register copies
  logic [1:0]         mode;
  logic               sub_mean;
  logic               cut_en;
  logic signed [31:0] cut_val;

  // volume state
  longint msum;
  longint wsum;
  longint mean;
  bit     mean_ok;
  bit     closed;
  int     errs = 0;

  function automatic longint sat32(longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  function automatic longint acc_add(longint s, longint d);
    longint mx;
    longint mn;
    mx = (longint'(1) << (ACC_W - 1)) - 1;
    mn = -mx - 1;
    if (d > 0 && s > mx - d) return mx;
    if (d < 0 && s < mn - d) return mn;
    return s + d;
  endfunction

  // sum * 2^16 / weight, truncated toward zero, restoring division on magnitudes
  function automatic longint region_mean_of(longint s, longint w);
    bit [63:0] uw;
    bit [63:0] mag;
    bit [63:0] q;
    bit [63:0] r;
    bit [63:0] frac;
    bit        top;
    uw   = w;
    mag  = (s < 0) ? 64'(-s) : 64'(s);
    q    = mag / uw;
    r    = mag % uw;
    frac = '0;
    if (q > 64'd32768) return (s < 0) ? longint'(Q_MIN) : longint'(Q_MAX);
    for (int i = 0; i < FRAC_W; i++) begin
      top  = r[63];
      r    = r << 1;
      frac = frac << 1;
      if (top || r >= uw) begin
        r       = r - uw;
        frac[0] = 1'b1;
      end
    end
    mag = (q << FRAC_W) | frac;
    if (s < 0) return sat32(-longint'(mag));
    return sat32(longint'(mag));
  endfunction

  function automatic bit cut_hit(longint msk);
    if (mode == MODE_CUT_ABOVE) return msk > cut_val;
    if (mode == MODE_CUT_BELOW) return msk < cut_val;
    return 1'b0;
  endfunction

  function automatic voxel_res_t masked_voxel(bit second, longint pix, longint msk, bit lst);
    longint     data;
    longint     wt;
    bit         used;
    voxel_res_t r;
    data = pix;
    wt   = longint'(Q_ONE);
    used = 1'b0;
    if (!second && closed) begin
      msum    = 0;
      wsum    = 0;
      mean    = 0;
      mean_ok = 1'b0;
      closed  = 1'b0;
    end
    if (second && mean_ok && mode != MODE_PASS) begin
      used = 1'b1;
      if (mode == MODE_MULTIPLY) data = sat32(((pix - mean) * msk) >>> FRAC_W);
      else data = cut_hit(msk) ? 0 : sat32(pix - mean);
    end else begin
      if (mode == MODE_MULTIPLY) begin
        data = sat32((pix * msk) >>> FRAC_W);
        wt   = (cut_en && msk < cut_val) ? 0 : msk;
      end else if (cut_hit(msk)) begin
        data = 0;
        wt   = 0;
      end
      if (!second) begin
        if (cut_en) begin
          msum = acc_add(msum, data);
          wsum = acc_add(wsum, wt);
        end
        if (lst) begin
          if (sub_mean && wsum > 0) begin
            mean    = region_mean_of(msum, wsum);
            mean_ok = 1'b1;
          end
          closed = 1'b1;
        end
      end
    end
    r.pixel     = data[31:0];
    r.mean_used = used;
    r.last_out  = lst;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    voxel_res_t want;
    if (!rst_n) begin
      expected_voxels.delete();
      mode     = MODE_CUT_ABOVE;
      sub_mean = 1'b0;
      cut_en   = 1'b0;
      cut_val  = '0;
      msum     = 0;
      wsum     = 0;
      mean     = 0;
      mean_ok  = 1'b0;
      closed   = 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASK_MODE:     mode = cfg_data[1:0];
          REG_SUBTRACT_MEAN: sub_mean = cfg_data[0];
          REG_CUT_ENABLE:    cut_en = cfg_data[0];
          REG_CUT_VALUE:     cut_val = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_voxels.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word, actual %h/%b/%b", $time,
                   out_tdata, out_tuser, out_tlast);
        end else begin
          want = expected_voxels.pop_front();
          if (out_tdata !== want.pixel) begin
            errs++;
            $display("%0t: pixel_out expected %h actual %h", $time, want.pixel, out_tdata);
          end
          if (out_tuser !== want.mean_used) begin
            errs++;
            $display("%0t: mean_valid expected %b actual %b", $time, want.mean_used,
                     out_tuser);
          end
          if (out_tlast !== want.last_out) begin
            errs++;
            $display("%0t: last_out expected %b actual %b", $time, want.last_out, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_voxels.push_back(masked_voxel(in_tuser, $signed(in_tdata[31:0]),
                                               $signed(in_tdata[63:32]), in_tlast));
    end
    fail_count <= errs;
    pending    <= expected_voxels.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict; all prediction lives in voxel_mask_checker.
module testbench;
  import mbims_pkg::*;

  localparam int ACC_W       = 64;
  localparam int RAND_WORDS  = 1700;
  // input is held off after the closing pass-1 word while it drains (longer while
  // its result waits on the output) and, when a mean is formed, while the divider runs
  localparam int SETTLE      = ACC_W + 24;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;     // [31:0] pixel_value, [63:32] mask_value
  logic        in_tuser;     // [0] opcode
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] pixel_out
  logic        out_tuser;    // [0] mean_valid
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count;
  int pending;

  // idle odds in percent, changed by the stimulus as the run moves on
  int send_idle_pct = 27;
  int recv_idle_pct = 86;
  bit hold_req      = 1'b0;
  int words_sent    = 0;

  // one volume's voxels, replayed for pass 2
  logic [31:0] pix_buf [64];
  logic [31:0] msk_buf [64];
  logic [31:0] cut_now = '0;

  always #5 clk = ~clk;

  mask_by_image_mean_subtract_top #(.ACC_WIDTH(ACC_W)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  voxel_mask_checker #(.ACC_W(ACC_W)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Result side: random back-pressure, or a long hold-off on request so the
  // pipeline fills and in_tready drops while words keep being offered.
  initial begin : result_sink
    int k;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Q16.16 value: rails, zero, a few units around zero, or anything
  function automatic logic [31:0] pick_q();
    case ($urandom_range(7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3, 4:    return 32'($urandom_range(4 * 65536)) - 32'(2 * 65536);
      default: return $urandom();
    endcase
  endfunction

  // masks cluster around the cut so both sides of the compare get hit
  function automatic logic [31:0] pick_mask();
    if ($urandom_range(2) == 0) return cut_now + 32'($urandom_range(4)) - 32'd2;
    return pick_q();
  endfunction

  task automatic send_word(input logic op, input logic [31:0] pix, input logic [31:0] msk,
                           input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {msk, pix};
    in_tuser  <= op;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // replay the buffered volume as one pass, tlast on the final voxel
  task automatic send_pass(input logic op, input int n);
    for (int i = 0; i < n; i++) send_word(op, pix_buf[i], msk_buf[i], i == n - 1);
  endtask

  // config only goes in once every result is back and the divider is done
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller drops it once the group of writes is done
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CUT_VALUE) cut_now = val;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic sub, input logic cut_en,
                            input logic [31:0] cut);
    wait_idle();
    write_reg(REG_MASK_MODE, {30'd0, mode});
    write_reg(REG_SUBTRACT_MEAN, {31'd0, sub});
    write_reg(REG_CUT_ENABLE, {31'd0, cut_en});
    write_reg(REG_CUT_VALUE, cut);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    wait_idle();
    if ($urandom_range(1)) write_reg(REG_MASK_MODE, 32'($urandom_range(3)));
    if ($urandom_range(3)) write_reg(REG_SUBTRACT_MEAN, 32'($urandom_range(3) != 0));
    if ($urandom_range(1)) write_reg(REG_CUT_ENABLE, 32'($urandom_range(4) != 0));
    if ($urandom_range(1)) write_reg(REG_CUT_VALUE, pick_q());
    cfg_valid <= 1'b0;
  endtask

  // run limit, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int  n;
    bit  held;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_PASS1;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MASK_MODE;
    cfg_data   = '0;
    held       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // cut above 0 with rails; mode switched to multiply between the passes,
    // so pass 2 applies the mean under the new mode
    set_config(MODE_CUT_ABOVE, 1'b1, 1'b1, 32'd0);
    pix_buf[0] = Q_MAX;  msk_buf[0] = 32'hffff_ffff;
    pix_buf[1] = Q_MIN;  msk_buf[1] = 32'd1;
    pix_buf[2] = Q_ONE;  msk_buf[2] = Q_MIN;
    send_pass(OP_PASS1, 3);
    wait_idle();
    write_reg(REG_MASK_MODE, {30'd0, MODE_MULTIPLY});
    cfg_valid <= 1'b0;
    send_pass(OP_PASS2, 3);

    // cut below the top rail: only a full-scale mask survives
    set_config(MODE_CUT_BELOW, 1'b1, 1'b1, Q_MAX);
    pix_buf[0] = Q_MAX;  msk_buf[0] = Q_MAX;
    pix_buf[1] = Q_MIN;  msk_buf[1] = '0;
    send_pass(OP_PASS1, 2);
    send_pass(OP_PASS2, 2);

    // multiply saturating both ways, tiny mask as weight
    set_config(MODE_MULTIPLY, 1'b1, 1'b1, Q_MIN);
    pix_buf[0] = Q_MAX;  msk_buf[0] = Q_MAX;
    pix_buf[1] = Q_MIN;  msk_buf[1] = Q_MAX;
    pix_buf[2] = Q_MAX;  msk_buf[2] = 32'd1;
    send_pass(OP_PASS1, 3);
    send_pass(OP_PASS2, 3);

    // negative masks cut to zero weight: no usable mean, pass 2 gets pass-1 math
    set_config(MODE_MULTIPLY, 1'b1, 1'b1, 32'd0);
    pix_buf[0] = Q_ONE;  msk_buf[0] = -Q_ONE;
    pix_buf[1] = Q_MAX;  msk_buf[1] = Q_MIN;
    send_pass(OP_PASS1, 2);
    send_pass(OP_PASS2, 1);

    // pass-through mode ignores the mean in pass 2
    set_config(MODE_PASS, 1'b1, 1'b1, 32'd0);
    pix_buf[0] = 32'h0003_0039;  msk_buf[0] = Q_MIN;
    send_pass(OP_PASS1, 1);
    send_pass(OP_PASS2, 1);

    // pass 2 while pass 1 is still open
    set_config(MODE_CUT_ABOVE, 1'b1, 1'b1, Q_ONE);
    send_word(OP_PASS1, 32'h0002_0000, 32'h0000_8000, 1'b0);
    send_word(OP_PASS2, 32'h0005_0000, 32'h0000_8000, 1'b1);
    send_word(OP_PASS1, 32'hfffe_0000, 32'h0002_0000, 1'b1);

    // --- random volumes ---
    // thirds: sender idles 27 / receiver 86, then swapped, then no idling
    while (words_sent < RAND_WORDS) begin
      if (words_sent < RAND_WORDS / 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 86;
      end else if (words_sent < 2 * RAND_WORDS / 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      // one long stall on the result side once idling is off
      if (send_idle_pct == 0 && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        pix_buf[i] = pick_q();
        msk_buf[i] = pick_mask();
      end
      if ($urandom_range(9) < 8) begin
        // well-formed volume: pass 1, maybe a mode change, then one or two pass 2
        send_pass(OP_PASS1, n);
        if ($urandom_range(4) == 0) begin
          wait_idle();
          write_reg(REG_MASK_MODE, 32'($urandom_range(3)));
          cfg_valid <= 1'b0;
        end
        send_pass(OP_PASS2, n);
        if ($urandom_range(5) == 0) send_pass(OP_PASS2, n);
      end else begin
        // noise: passes mixed and tlast anywhere
        for (int i = 0; i < n; i++)
          send_word(logic'($urandom_range(1)), pix_buf[i], msk_buf[i],
                    $urandom_range(3) == 0);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
